[src/ousl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ousl_pkg;

  // default list capacity
  localparam int unsigned DEF_CAPACITY = 64;

  // fixed field widths
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 7;

  // value reported when there is none
  localparam logic [VALUE_W-1:0] NONE_VALUE = 16'hffff;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_DUP       = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_SHIFT  = 4'b0100,
    ST_READ   = 4'b1000
  } state_e;

endpackage

`default_nettype wire

[src/ousl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ousl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[src/ordered_unique_seqnum_list.sv]
`timescale 1ns / 1ps
`default_nettype none

// Insertion-ordered list of unique 16-bit sequence numbers held in one RAM of CAPACITY
// entries. A command is taken when start_i is high and busy_o is low; its result shows
// for one cycle with done_o high and cannot be held off by the receiver. Clear, unused
// codes, any command on an empty list and get_ith past the last entry finish straight
// from idle; get_ith inside the list first reads its entry from the RAM. Insert, find
// and delete search the list one entry per cycle through the single RAM read port, so
// an insert into a full list searches the whole list for a duplicate before it reports
// full. A delete then closes the gap by moving every later entry down, one per cycle.
// Delete_first reads the head and shifts the same way. No clearing pass follows reset:
// only the first count entries are ever read.
module ordered_unique_seqnum_list #(
  parameter int unsigned CAPACITY = ousl_pkg::DEF_CAPACITY
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [ousl_pkg::CMD_W-1:0]     command_i,
  input  wire logic [ousl_pkg::VALUE_W-1:0]   value_i,
  input  wire logic [ousl_pkg::POS_W-1:0]     position_i,
  output logic                                done_o,
  output logic      [ousl_pkg::VALUE_W-1:0]   result_value_o,
  output logic      [ousl_pkg::STATUS_W-1:0]  status_o,
  output logic      [ousl_pkg::COUNT_W-1:0]   count_o
);

  import ousl_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (OW > POS_W) ? OW : POS_W;

  state_e               state_q, state_d;
  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [VALUE_W-1:0]   val_q, val_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [OW-1:0]        occ_q, occ_d;
  logic                 done_q, done_d;
  logic [VALUE_W-1:0]   res_q, res_d;
  logic [STATUS_W-1:0]  status_q, status_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [VALUE_W-1:0]   ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [VALUE_W-1:0]   ram_rdata;

  logic [PW-1:0]        pos_eff;
  logic [PW-1:0]        occ_ext;
  logic                 hit;
  logic                 last;
  logic                 shift_end;

  // entry store
  ousl_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // position 0 acts as 1
  assign pos_eff = (position_i == '0) ? PW'(1) : PW'(position_i);
  assign occ_ext = PW'(occ_q);

  // search and shift progress
  assign hit       = (cmd_q == CMD_POP) || (ram_rdata == val_q);
  assign last      = (OW'(idx_q) + OW'(1)) == occ_q;
  assign shift_end = (OW'(idx_q) + OW'(2)) == occ_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    idx_d     = idx_q;
    occ_d     = occ_q;
    done_d    = 1'b0;
    res_d     = res_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    ram_raddr = idx_q + AW'(1);

    case (state_q)
      ST_IDLE: begin
        ram_raddr = '0;
        if (start_i) begin
          cmd_d = command_i;
          val_d = value_i;
          idx_d = '0;
          case (command_i)
            CMD_INSERT: begin
              if (occ_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = value_i;
                occ_d     = OW'(1);
                done_d    = 1'b1;
                res_d     = value_i;
                status_d  = STAT_OK;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            CMD_DELETE, CMD_FIND, CMD_POP: begin
              if (occ_q == '0) begin
                done_d   = 1'b1;
                res_d    = NONE_VALUE;
                status_d = STAT_EMPTY;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            CMD_GET: begin
              if (occ_q == '0) begin
                done_d   = 1'b1;
                res_d    = NONE_VALUE;
                status_d = STAT_EMPTY;
              end else if (pos_eff > occ_ext) begin
                done_d   = 1'b1;
                res_d    = NONE_VALUE;
                status_d = STAT_NOT_FOUND;
              end else begin
                ram_raddr = AW'(pos_eff - PW'(1));
                state_d   = ST_READ;
              end
            end
            CMD_CLEAR: begin
              occ_d    = '0;
              done_d   = 1'b1;
              res_d    = NONE_VALUE;
              status_d = STAT_OK;
            end
            default: begin
              done_d   = 1'b1;
              res_d    = NONE_VALUE;
              status_d = STAT_OK;
            end
          endcase
        end
      end

      // ram_rdata holds entry idx_q, next entry already being read
      ST_SEARCH: begin
        if (hit) begin
          case (cmd_q)
            CMD_INSERT: begin
              done_d   = 1'b1;
              res_d    = val_q;
              status_d = STAT_DUP;
              state_d  = ST_IDLE;
            end
            CMD_FIND: begin
              done_d   = 1'b1;
              res_d    = val_q;
              status_d = STAT_OK;
              state_d  = ST_IDLE;
            end
            default: begin
              val_d = ram_rdata;
              if (last) begin
                occ_d    = occ_q - OW'(1);
                done_d   = 1'b1;
                res_d    = ram_rdata;
                status_d = STAT_OK;
                state_d  = ST_IDLE;
              end else begin
                state_d = ST_SHIFT;
              end
            end
          endcase
        end else if (last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          if (cmd_q == CMD_INSERT) begin
            if (occ_q == OW'(CAPACITY)) begin
              res_d    = NONE_VALUE;
              status_d = STAT_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(occ_q);
              ram_wdata = val_q;
              occ_d     = occ_q + OW'(1);
              res_d     = val_q;
              status_d  = STAT_OK;
            end
          end else begin
            res_d    = NONE_VALUE;
            status_d = STAT_NOT_FOUND;
          end
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      // move entry idx_q+1 down to idx_q
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        ram_raddr = idx_q + AW'(2);
        if (shift_end) begin
          occ_d    = occ_q - OW'(1);
          done_d   = 1'b1;
          res_d    = val_q;
          status_d = STAT_OK;
          state_d  = ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      ST_READ: begin
        done_d   = 1'b1;
        res_d    = ram_rdata;
        status_d = STAT_OK;
        state_d  = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    res_q    <= res_d;
    status_q <= status_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign count_o        = COUNT_W'(occ_q);

  // a result only appears once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // occupancy never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(CAPACITY))
    else $error("occupancy beyond capacity");

  // the search pointer stays inside the occupied part of the list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (OW'(idx_q) < occ_q))
    else $error("search pointer past last entry");

  // a gap shift ends with one entry fewer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SHIFT) && shift_end) |=> (occ_q == $past(occ_q) - OW'(1)))
    else $error("shift did not shrink the list");

endmodule

`default_nettype wire

[tb/ordered_unique_seqnum_list_checker.sv]
`timescale 1ns / 1ps

module ordered_unique_seqnum_list_checker #(
  parameter int unsigned CAPACITY = ousl_pkg::DEF_CAPACITY
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          busy_i,
  input  wire logic [ousl_pkg::CMD_W-1:0]    command_i,
  input  wire logic [ousl_pkg::VALUE_W-1:0]  value_i,
  input  wire logic [ousl_pkg::POS_W-1:0]    position_i,
  input  wire logic                          done_i,
  input  wire logic [ousl_pkg::VALUE_W-1:0]  result_value_i,
  input  wire logic [ousl_pkg::STATUS_W-1:0] status_i,
  input  wire logic [ousl_pkg::COUNT_W-1:0]  count_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        checked_o
);

  import ousl_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  // shadow copy of the list, oldest first
  logic [VALUE_W-1:0] shadow_entries [CAPACITY];
  int unsigned        shadow_len;

  list_result_t       expected_results_q [$];
  int unsigned        fail_total;
  int unsigned        checked_total;

  // index of v in the shadow list, or its length when absent
  function automatic int unsigned shadow_index_of(input logic [VALUE_W-1:0] v);
    for (int unsigned k = 0; k < shadow_len; k++) begin
      if (shadow_entries[k] == v) return k;
    end
    return shadow_len;
  endfunction

  // remove entry k and close the gap
  function automatic void shadow_remove(input int unsigned k);
    for (int unsigned j = k; j + 1 < shadow_len; j++) begin
      shadow_entries[j] = shadow_entries[j + 1];
    end
    if (shadow_len > 0) shadow_len--;
  endfunction

  // apply one command to the shadow list and return what the block must report
  function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [VALUE_W-1:0] val,
                                                      input logic [POS_W-1:0] pos);
    list_result_t r;
    int unsigned  k;
    int unsigned  slot;
    r.value  = NONE_VALUE;
    r.status = STAT_OK;
    slot     = (pos == '0) ? 1 : int'(pos);
    case (cmd)
      CMD_INSERT: begin
        if (shadow_index_of(val) < shadow_len) begin
          r.value  = val;
          r.status = STAT_DUP;
        end else if (shadow_len >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
          r.value = val;
        end
      end
      CMD_DELETE, CMD_FIND: begin
        if (shadow_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          k = shadow_index_of(val);
          if (k >= shadow_len) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.value = val;
            if (cmd == CMD_DELETE) shadow_remove(k);
          end
        end
      end
      CMD_POP: begin
        if (shadow_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.value = shadow_entries[0];
          shadow_remove(0);
        end
      end
      CMD_GET: begin
        if (shadow_len == 0) r.status = STAT_EMPTY;
        else if (slot > shadow_len || slot > CAPACITY) r.status = STAT_NOT_FOUND;
        else r.value = shadow_entries[slot - 1];
      end
      CMD_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.count = COUNT_W'(shadow_len);
    return r;
  endfunction

  // compare results first, then record the item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      shadow_len    = 0;
      fail_total    = 0;
      checked_total = 0;
      expected_results_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (done_i) begin
        checked_total++;
        if (expected_results_q.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("%0t: result with none expected: value %h status %0d count %0d",
                     $realtime, result_value_i, status_i, count_i);
        end else begin
          want = expected_results_q.pop_front();
          if (want.value !== result_value_i || want.status !== status_i ||
              want.count !== count_i) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display({"%0t: mismatch: expected value %h status %0d count %0d, ",
                        "got value %h status %0d count %0d"},
                       $realtime, want.value, want.status, want.count,
                       result_value_i, status_i, count_i);
          end
        end
      end
      if (start_i && !busy_i)
        expected_results_q.push_back(apply_list_command(command_i, value_i, position_i));
      fail_count_o <= fail_total;
      pending_o    <= expected_results_q.size();
      checked_o    <= checked_total;
    end
  end

endmodule

[tb/ordered_unique_seqnum_list_tb.sv]
`timescale 1ns / 1ps

module ordered_unique_seqnum_list_tb;
  import ousl_pkg::*;

  localparam int unsigned LIST_DEPTH   = DEF_CAPACITY;
  localparam int unsigned RANDOM_ITEMS = 1125;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned RECENT_DEPTH = 96;

  // codes the block does not use
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN, PH_NOISE} phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CMD_W-1:0]    command_i;
  logic [VALUE_W-1:0]  value_i;
  logic [POS_W-1:0]    position_i;
  logic                done_o;
  logic [VALUE_W-1:0]  result_value_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  count_o;

  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned results_checked;

  int unsigned        items_sent;
  int unsigned        phases_run;
  logic [VALUE_W-1:0] recent_values_q [$];

  ordered_unique_seqnum_list #(
    .CAPACITY(LIST_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .status_o      (status_o),
    .count_o       (count_o)
  );

  ordered_unique_seqnum_list_checker #(
    .CAPACITY(LIST_DEPTH)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .command_i     (command_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .done_i        (done_o),
    .result_value_i(result_value_o),
    .status_i      (status_o),
    .count_i       (count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_results),
    .checked_o     (results_checked)
  );

  // 4 ns clock
  always #2 clk_i = ~clk_i;

  // hold one item on the inputs until the block takes it; start stays high afterwards
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    bit taken;
    start_i    = 1'b1;
    command_i  = cmd;
    value_i    = val;
    position_i = pos;
    taken      = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
      @(negedge clk_i);
    end
    items_sent++;
    if (cmd == CMD_INSERT) begin
      recent_values_q.push_back(val);
      if (recent_values_q.size() > RECENT_DEPTH) void'(recent_values_q.pop_front());
    end
  endtask

  // sender gap with junk on the fields
  task automatic idle_cycles(input int unsigned n);
    if (n > 0) start_i = 1'b0;
    repeat (n) begin
      command_i  = CMD_W'($urandom);
      value_i    = VALUE_W'($urandom);
      position_i = POS_W'($urandom);
      @(negedge clk_i);
    end
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_drained();
    start_i = 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // value likely to be in the list with the given percentage
  function automatic logic [VALUE_W-1:0] pick_value(input int unsigned known_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < known_pct && recent_values_q.size() > 0)
      return recent_values_q[$urandom_range(0, recent_values_q.size() - 1)];
    if (r >= 95) return (r[0]) ? NONE_VALUE : '0;
    return VALUE_W'($urandom);
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom);
    return POS_W'($urandom_range(0, LIST_DEPTH + 4));
  endfunction

  initial begin
    phase_e             kind;
    int unsigned        phase_len;
    int unsigned        r;
    bit                 quiet;
    logic [CMD_W-1:0]   cmd;

    rst_ni     = 1'b0;
    start_i    = 1'b0;
    command_i  = CMD_INSERT;
    value_i    = '0;
    position_i = '0;
    items_sent = 0;
    phases_run = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty list on every read path
    send_item(CMD_GET, 16'h0000, 7'd0);
    send_item(CMD_POP, 16'h0000, 7'd0);
    send_item(CMD_FIND, 16'h1234, 7'd0);
    send_item(CMD_DELETE, 16'h1234, 7'd0);
    // extremes, including the all-ones value that must dedupe too
    send_item(CMD_INSERT, 16'h0000, 7'd0);
    send_item(CMD_INSERT, NONE_VALUE, 7'd0);
    send_item(CMD_INSERT, NONE_VALUE, 7'd0);
    send_item(CMD_INSERT, 16'h0000, 7'd0);
    send_item(CMD_INSERT, 16'h8001, 7'd0);
    send_item(CMD_FIND, NONE_VALUE, 7'd0);
    send_item(CMD_FIND, 16'h7ffe, 7'd0);
    send_item(CMD_DELETE, 16'h7ffe, 7'd0);
    // position zero acts as one, the last entry, past the end, the widest position, spare codes
    send_item(CMD_GET, 16'h0000, 7'd0);
    send_item(CMD_GET, 16'h0000, 7'd3);
    send_item(CMD_GET, 16'h0000, 7'd4);
    send_item(CMD_GET, 16'hffff, 7'd127);
    send_item(CMD_SPARE6, NONE_VALUE, 7'd127);
    send_item(CMD_SPARE7, 16'h5555, 7'd1);
    // delete from the middle, pop, then check the compacted order
    send_item(CMD_DELETE, NONE_VALUE, 7'd0);
    send_item(CMD_POP, 16'h0000, 7'd0);
    send_item(CMD_GET, 16'h0000, 7'd1);
    // clear, then make sure nothing stale survives
    send_item(CMD_CLEAR, 16'h0000, 7'd0);
    send_item(CMD_GET, 16'h0000, 7'd1);
    send_item(CMD_INSERT, NONE_VALUE, 7'd0);
    send_item(CMD_POP, 16'h0000, 7'd0);
    wait_drained();

    // random phases of well-formed traffic with some noise
    while (items_sent < 25 + RANDOM_ITEMS) begin
      kind      = phase_e'($urandom_range(0, 3));
      phase_len = (kind == PH_FILL) ? $urandom_range(70, 90) : $urandom_range(15, 60);
      quiet     = ($urandom_range(0, 3) == 0);
      phases_run++;
      for (int unsigned i = 0; i < phase_len; i++) begin
        r = $urandom_range(0, 99);
        case (kind)
          PH_FILL: begin
            if (r < 85) send_item(CMD_INSERT, pick_value(30), '0);
            else if (r < 93) send_item(CMD_FIND, pick_value(70), '0);
            else send_item(CMD_GET, '0, pick_position());
          end
          PH_CHURN: begin
            if (r < 30) cmd = CMD_INSERT;
            else if (r < 50) cmd = CMD_DELETE;
            else if (r < 70) cmd = CMD_FIND;
            else if (r < 85) cmd = CMD_GET;
            else if (r < 95) cmd = CMD_POP;
            else if (r < 97) cmd = CMD_CLEAR;
            else cmd = (r[0]) ? CMD_SPARE7 : CMD_SPARE6;
            send_item(cmd, pick_value(70), pick_position());
          end
          PH_DRAIN: begin
            if (r < 40) send_item(CMD_POP, VALUE_W'($urandom), '0);
            else if (r < 70) send_item(CMD_DELETE, pick_value(80), '0);
            else if (r < 90) send_item(CMD_GET, '0, pick_position());
            else send_item(CMD_FIND, pick_value(60), '0);
          end
          default: begin
            send_item(CMD_W'($urandom), VALUE_W'($urandom), POS_W'($urandom));
          end
        endcase
        if (!quiet) idle_cycles(pick_gap());
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    // let everything come back, then allow for the longest command
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("sent %0d commands over %0d random phases after the directed cases",
             items_sent, phases_run);
    $display("checked %0d results against the shadow list", results_checked);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[ordered_unique_seqnum_list] OK");
    end else begin
      $display("[ordered_unique_seqnum_list] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", pending_results);
    $display("[ordered_unique_seqnum_list] ERROR");
    $finish;
  end

endmodule
